@@ rtl/nrki_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrki_pkg
// Shared constants for the note ring with key index: opcodes and field widths.
// ----------------------------------------------------------------------------
package nrki_pkg;

  localparam int OPCODE_W   = 3;
  localparam int NUM_W      = 7;
  localparam int PHASE_W    = 3;
  localparam int NOTE_DATA_W = 32;
  localparam int OUT_SLOT_W = 5;
  localparam int KEY_COUNT  = 128;

  localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_READ    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FIND    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 3'd5;

  localparam logic [PHASE_W-1:0] END_PHASE_RESET = 3'd7;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [NUM_W-1:0]    note_num_t;
  typedef logic [PHASE_W-1:0]  phase_t;

endpackage : nrki_pkg
`default_nettype wire

@@ rtl/nrki_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrki_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module nrki_ram #(
  parameter int DEPTH = 17,
  parameter int WIDTH = 42,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : nrki_ram
`default_nettype wire

@@ rtl/note_ring_with_key_index_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// note_ring_with_key_index_top
// Note FIFO for a voice engine: a ring of POLYPHONY+1 note slots with start,
// write and read cursors, plus a 128-entry key table mapping each note number
// to the slot of its newest write.
// ----------------------------------------------------------------------------
// Each transaction is accepted in the idle state. The note store and key
// table RAMs have registered reads: the accept cycle issues the reads, the
// execute state reads, modifies and writes back (find chains a table read
// into a store read and completes in the find state). One operation is
// in flight at a time; a result waiting in the output register does not block
// acceptance of the next transaction, only its completion. No clearing pass is
// needed after reset: key table entries carry valid flops that reset and the
// clear operation drop at once. end_phase may be written at any time the block
// is idle and applies to the next read.
// ----------------------------------------------------------------------------
module note_ring_with_key_index_top #(
  parameter int POLYPHONY = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [6:0]  in_note_num,
  input  wire logic [2:0]  in_note_phase,
  input  wire logic [31:0] in_note_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [4:0]       out_slot,
  output logic [6:0]       out_num,
  output logic [2:0]       out_phase,
  output logic [31:0]      out_data
);

  localparam int RING_SLOTS = POLYPHONY + 1;
  localparam int SLOT_W     = $clog2(RING_SLOTS);
  localparam int ENTRY_W    = nrki_pkg::NUM_W + nrki_pkg::PHASE_W + DATA_BITS;
  localparam int KEY_AW     = $clog2(nrki_pkg::KEY_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POLYPHONY);
  localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = (s == SLOT_LAST) ? '0 : SLOT_W'(s + 1'b1);
    return r;
  endfunction

  // control state
  logic [1:0]                 state_r, state_nxt;
  logic [SLOT_W-1:0]          start_r, start_nxt;
  logic [SLOT_W-1:0]          wr_cur_r, wr_cur_nxt;
  logic [SLOT_W-1:0]          rd_cur_r, rd_cur_nxt;
  logic [nrki_pkg::KEY_COUNT-1:0] key_valid_r, key_valid_nxt;
  nrki_pkg::phase_t           end_phase_r;

  // latched transaction
  nrki_pkg::opcode_t          op_r;
  nrki_pkg::note_num_t        num_r;
  nrki_pkg::phase_t           phase_r;
  logic [DATA_BITS-1:0]       data_r;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic                       res_ok_r, res_ok_nxt;
  logic [4:0]                 res_slot_r, res_slot_nxt;
  nrki_pkg::note_num_t        res_num_r, res_num_nxt;
  nrki_pkg::phase_t           res_phase_r, res_phase_nxt;
  logic [31:0]                res_data_r, res_data_nxt;

  // memory ports
  logic                       store_we, store_re;
  logic [SLOT_W-1:0]          store_waddr, store_raddr;
  logic [ENTRY_W-1:0]         store_wdata, store_rdata;
  logic                       key_we;
  logic [SLOT_W-1:0]          key_rdata;

  logic                       in_acc, out_free, done;
  logic                       empty, full, read_ok;
  nrki_pkg::note_num_t        e_num;
  nrki_pkg::phase_t           e_phase, stamped_phase;
  logic [DATA_BITS-1:0]       e_data;
  logic [SLOT_W-1:0]          rd_next;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign done     = out_free &&
                    (((state_r == ST_EXEC) && (op_r != nrki_pkg::OP_FIND)) ||
                     (state_r == ST_FIND));

  assign {e_num, e_phase, e_data} = store_rdata;
  assign empty   = (start_r == wr_cur_r);
  assign full    = (next_slot(wr_cur_r) == start_r);
  assign rd_next = next_slot(rd_cur_r);
  assign read_ok = !empty && (rd_next != wr_cur_r);
  assign stamped_phase = key_valid_r[e_num] ? e_phase : end_phase_r;

  // read issue: store at accept (read/remove) or after the table read (find)
  always_comb begin
    store_re    = 1'b0;
    store_raddr = start_r;
    if (in_acc) begin
      store_re    = 1'b1;
      store_raddr = (in_opcode == nrki_pkg::OP_READ) ? rd_next : start_r;
    end else if ((state_r == ST_EXEC) && (op_r == nrki_pkg::OP_FIND)) begin
      store_re    = 1'b1;
      store_raddr = key_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    wr_cur_nxt    = wr_cur_r;
    rd_cur_nxt    = rd_cur_r;
    key_valid_nxt = key_valid_r;
    store_we      = 1'b0;
    store_waddr   = wr_cur_r;
    store_wdata   = {num_r, phase_r, data_r};
    key_we        = 1'b0;
    res_ok_nxt    = 1'b0;
    res_slot_nxt  = '0;
    res_num_nxt   = '0;
    res_phase_nxt = '0;
    res_data_nxt  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == nrki_pkg::OP_FIND) begin
          state_nxt = ST_FIND;
        end else if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIND: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      case (op_r)
        nrki_pkg::OP_WRITE: begin
          if (!full) begin
            store_we           = 1'b1;
            key_we             = 1'b1;
            key_valid_nxt[num_r] = 1'b1;
            wr_cur_nxt         = next_slot(wr_cur_r);
            res_ok_nxt         = 1'b1;
            res_slot_nxt       = 5'(wr_cur_r);
            res_num_nxt        = num_r;
            res_phase_nxt      = phase_r;
            res_data_nxt       = 32'(data_r);
          end
        end
        nrki_pkg::OP_READ: begin
          if (read_ok) begin
            // write back the entry, stamped with the end phase if its key is released
            store_we      = 1'b1;
            store_waddr   = rd_next;
            store_wdata   = {e_num, stamped_phase, e_data};
            rd_cur_nxt    = rd_next;
            res_ok_nxt    = 1'b1;
            res_slot_nxt  = 5'(rd_next);
            res_num_nxt   = e_num;
            res_phase_nxt = stamped_phase;
            res_data_nxt  = 32'(e_data);
          end
        end
        nrki_pkg::OP_REMOVE: begin
          if (!empty) begin
            key_valid_nxt[e_num] = 1'b0;
            start_nxt     = next_slot(start_r);
            res_ok_nxt    = 1'b1;
            res_slot_nxt  = 5'(start_r);
            res_num_nxt   = e_num;
            res_phase_nxt = e_phase;
            res_data_nxt  = 32'(e_data);
          end
        end
        nrki_pkg::OP_FIND: begin
          if (!empty && key_valid_r[num_r]) begin
            res_ok_nxt    = 1'b1;
            res_slot_nxt  = 5'(key_rdata);
            res_num_nxt   = e_num;
            res_phase_nxt = e_phase;
            res_data_nxt  = 32'(e_data);
          end
        end
        nrki_pkg::OP_CLEAR: begin
          start_nxt     = SLOT_ONE;
          wr_cur_nxt    = SLOT_ONE;
          rd_cur_nxt    = '0;
          key_valid_nxt = '0;
          res_ok_nxt    = 1'b1;
        end
        nrki_pkg::OP_RESTART: begin
          rd_cur_nxt = (start_r == '0) ? SLOT_LAST : SLOT_W'(start_r - 1'b1);
          res_ok_nxt = 1'b1;
        end
        default: begin
          res_ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= SLOT_ONE;
      wr_cur_r    <= SLOT_ONE;
      rd_cur_r    <= '0;
      key_valid_r <= '0;
      end_phase_r <= nrki_pkg::END_PHASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      wr_cur_r    <= wr_cur_nxt;
      rd_cur_r    <= rd_cur_nxt;
      key_valid_r <= key_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        end_phase_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_opcode;
      num_r   <= in_note_num;
      phase_r <= in_note_phase;
      data_r  <= DATA_BITS'(in_note_data);
    end
    if (done) begin
      res_ok_r    <= res_ok_nxt;
      res_slot_r  <= res_slot_nxt;
      res_num_r   <= res_num_nxt;
      res_phase_r <= res_phase_nxt;
      res_data_r  <= res_data_nxt;
    end
  end

  nrki_ram #(
    .DEPTH  (RING_SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (SLOT_W)
  ) u_note_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_waddr),
    .wr_data (store_wdata),
    .rd_en   (store_re),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  nrki_ram #(
    .DEPTH  (nrki_pkg::KEY_COUNT),
    .WIDTH  (SLOT_W),
    .ADDR_W (KEY_AW)
  ) u_key_table (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (num_r),
    .wr_data (wr_cur_r),
    .rd_en   (in_acc),
    .rd_addr (in_note_num),
    .rd_data (key_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_ok    = res_ok_r;
  assign out_slot  = res_slot_r;
  assign out_num   = res_num_r;
  assign out_phase = res_phase_r;
  assign out_data  = res_data_r;

endmodule : note_ring_with_key_index_top
`default_nettype wire

@@ bench/note_ring_with_key_index_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_ring_with_key_index_top_tb
// Self-checking bench for the note ring. A driver sends queued operations
// with random gaps. A monitor applies random stalls and checks each result
// against an in-bench note ring that is updated as each transaction is
// accepted. The end-phase register is rewritten between phases while the
// ring is idle.
// ----------------------------------------------------------------------------
module note_ring_with_key_index_top_tb;

  localparam int POLYPHONY   = 16;
  localparam int RING_SLOTS  = POLYPHONY + 1;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES      = 8;
  localparam int QUIET_LIMIT = 2000;

  localparam nrki_pkg::opcode_t OP_RSVD6 = 3'd6;
  localparam nrki_pkg::opcode_t OP_RSVD7 = 3'd7;

  typedef struct packed {
    nrki_pkg::opcode_t   op;
    nrki_pkg::note_num_t num;
    nrki_pkg::phase_t    phase;
    logic [31:0]         data;
  } note_req_t;

  typedef struct packed {
    logic                ok;
    logic [4:0]          slot;
    nrki_pkg::note_num_t num;
    nrki_pkg::phase_t    phase;
    logic [31:0]         data;
  } note_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [6:0]  in_note_num = '0;
  logic [2:0]  in_note_phase = '0;
  logic [31:0] in_note_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [4:0]  out_slot;
  logic [6:0]  out_num;
  logic [2:0]  out_phase;
  logic [31:0] out_data;

  note_ring_with_key_index_top #(
    .POLYPHONY(POLYPHONY),
    .DATA_BITS(32)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_note_num  (in_note_num),
    .in_note_phase(in_note_phase),
    .in_note_data (in_note_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_slot     (out_slot),
    .out_num      (out_num),
    .out_phase    (out_phase),
    .out_data     (out_data)
  );

  always #5 clk = ~clk;

  // Note ring state as the bench sees it
  nrki_pkg::note_num_t ring_num   [RING_SLOTS];
  nrki_pkg::phase_t    ring_phase [RING_SLOTS];
  logic [31:0]         ring_data  [RING_SLOTS];
  logic [4:0]          key_slot   [nrki_pkg::KEY_COUNT];
  logic                key_live   [nrki_pkg::KEY_COUNT];
  logic [4:0]          head_slot;
  logic [4:0]          tail_slot;
  logic [4:0]          play_slot;
  nrki_pkg::phase_t    stamp_phase = nrki_pkg::END_PHASE_RESET;

  note_req_t  pending_ops[$];
  note_resp_t expected_results[$];
  note_req_t  cur_req;
  bit         presenting = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         sender_gap_max = 3;
  int         receiver_stall_max = 3;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  function automatic logic [4:0] ring_next(logic [4:0] s);
    return (s + 5'd1 >= 5'(RING_SLOTS)) ? 5'd0 : s + 5'd1;
  endfunction

  function automatic void restart_ring();
    head_slot = 5'd1;
    tail_slot = 5'd1;
    play_slot = 5'd0;
    for (int k = 0; k < nrki_pkg::KEY_COUNT; k++) key_live[k] = 1'b0;
  endfunction

  function automatic note_resp_t slot_result(logic [4:0] s);
    return {1'b1, s, ring_num[s], ring_phase[s], ring_data[s]};
  endfunction

  // Perform one ring operation and return the result it must produce.
  // Reads only ever reach slots written since reset: the read cursor never
  // passes the write cursor, and the key table only points at written slots.
  function automatic note_resp_t apply_note_op(note_req_t r);
    note_resp_t res;
    logic       empty;
    res = '0;
    empty = (head_slot == tail_slot);
    case (r.op)
      nrki_pkg::OP_WRITE: begin
        if (ring_next(tail_slot) != head_slot) begin
          ring_num[tail_slot] = r.num;
          ring_phase[tail_slot] = r.phase;
          ring_data[tail_slot] = r.data;
          key_slot[r.num] = tail_slot;
          key_live[r.num] = 1'b1;
          res = slot_result(tail_slot);
          tail_slot = ring_next(tail_slot);
        end
      end
      nrki_pkg::OP_READ: begin
        if (!empty && ring_next(play_slot) != tail_slot) begin
          play_slot = ring_next(play_slot);
          // released key: mark the note as ending
          if (!key_live[ring_num[play_slot]]) ring_phase[play_slot] = stamp_phase;
          res = slot_result(play_slot);
        end
      end
      nrki_pkg::OP_REMOVE: begin
        if (!empty) begin
          // drop the key even when it points at a newer copy
          key_live[ring_num[head_slot]] = 1'b0;
          res = slot_result(head_slot);
          head_slot = ring_next(head_slot);
        end
      end
      nrki_pkg::OP_FIND: begin
        if (!empty && key_live[r.num]) res = slot_result(key_slot[r.num]);
      end
      nrki_pkg::OP_CLEAR: begin
        restart_ring();
        res.ok = 1'b1;
      end
      nrki_pkg::OP_RESTART: begin
        play_slot = (head_slot == 5'd0) ? 5'(POLYPHONY) : head_slot - 5'd1;
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void queue_req(nrki_pkg::opcode_t op, nrki_pkg::note_num_t num,
                                    nrki_pkg::phase_t ph, logic [31:0] d);
    pending_ops.push_back({op, num, ph, d});
  endfunction

  // profile 0 balanced, 1 fills the ring, 2 drains it
  function automatic note_req_t random_req(int profile, int nbase);
    note_req_t r;
    int        pick;
    int        lim_wr, lim_rd, lim_rm, lim_fd, lim_rs, lim_cl;
    case (profile)
      1: begin
        lim_wr = 55; lim_rd = 70; lim_rm = 80; lim_fd = 92; lim_rs = 97; lim_cl = 98;
      end
      2: begin
        lim_wr = 30; lim_rd = 45; lim_rm = 75; lim_fd = 90; lim_rs = 96; lim_cl = 98;
      end
      default: begin
        lim_wr = 35; lim_rd = 55; lim_rm = 78; lim_fd = 93; lim_rs = 97; lim_cl = 98;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < lim_wr)      r.op = nrki_pkg::OP_WRITE;
    else if (pick < lim_rd) r.op = nrki_pkg::OP_READ;
    else if (pick < lim_rm) r.op = nrki_pkg::OP_REMOVE;
    else if (pick < lim_fd) r.op = nrki_pkg::OP_FIND;
    else if (pick < lim_rs) r.op = nrki_pkg::OP_RESTART;
    else if (pick < lim_cl) r.op = nrki_pkg::OP_CLEAR;
    else                    r.op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
    // keep most keys in a narrow window so finds hit and keys repeat
    if ($urandom_range(0, 9) < 6) begin
      r.num = nrki_pkg::note_num_t'(nbase + $urandom_range(0, 7));
    end else begin
      r.num = nrki_pkg::note_num_t'($urandom_range(0, 127));
    end
    r.phase = nrki_pkg::phase_t'($urandom_range(0, 7));
    r.data = $urandom;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ops.size() != 0 || presenting || expected_results.size() != 0);
  endtask

  task automatic write_end_phase(input nrki_pkg::phase_t v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stamp_phase = v;
  endtask

  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_note_op(cur_req));
        presenting = 1'b0;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        cur_req = pending_ops.pop_front();
        presenting = 1'b1;
        in_valid <= 1'b1;
        in_opcode <= cur_req.op;
        in_note_num <= cur_req.num;
        in_note_phase <= cur_req.phase;
        in_note_data <= cur_req.data;
        gap_left = $urandom_range(0, sender_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : collect_results
    note_resp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no operation outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_ok));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("out_num", 32'(want.num), 32'(out_num));
          check_field("out_phase", 32'(want.phase), 32'(out_phase));
          check_field("out_data", want.data, out_data);
        end
        stall_left = $urandom_range(0, receiver_stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int               phase_idx;
    int               nbase;
    nrki_pkg::phase_t cfg_val;
    restart_ring();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring and spare opcodes
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_REMOVE, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_FIND, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_RESTART, 7'd0, 3'd0, 32'h0);
    queue_req(OP_RSVD6, 7'd127, 3'd7, 32'hffff_ffff);
    queue_req(OP_RSVD7, 7'd127, 3'd7, 32'hffff_ffff);
    // two copies of one key, then lookups
    queue_req(nrki_pkg::OP_WRITE, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_WRITE, 7'd127, 3'd7, 32'hffff_ffff);
    queue_req(nrki_pkg::OP_WRITE, 7'd127, 3'd3, 32'ha5a5_5a5a);
    queue_req(nrki_pkg::OP_FIND, 7'd127, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_FIND, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_FIND, 7'd55, 3'd0, 32'h0);
    // read to the end of the ring
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    // removing the old copy releases the key; a later read stamps the end phase
    queue_req(nrki_pkg::OP_REMOVE, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_RESTART, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_REMOVE, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_FIND, 7'd127, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_RESTART, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_CLEAR, 7'd0, 3'd0, 32'h0);
    queue_req(nrki_pkg::OP_READ, 7'd0, 3'd0, 32'h0);
    wait_drained();

    for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      if (phase_idx == 0)      cfg_val = 3'd0;
      else if (phase_idx == 1) cfg_val = 3'd7;
      else                     cfg_val = nrki_pkg::phase_t'($urandom_range(0, 7));
      write_end_phase(cfg_val);
      sender_gap_max     = (phase_idx % 3 == 0) ? 0 : 6;
      receiver_stall_max = (phase_idx % 4 == 1 || phase_idx == 0) ? 0 : 6;
      if (phase_idx == 0)      nbase = 0;
      else if (phase_idx == 1) nbase = 120;
      else                     nbase = $urandom_range(0, 120);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pending_ops.push_back(random_req(phase_idx % 3, nbase));
      end
      // hold the sender until every result of the phase is back
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/nrki_pkg.sv
rtl/nrki_ram.sv
rtl/note_ring_with_key_index_top.sv
bench/note_ring_with_key_index_top_tb.sv
